@@ sv/chm_pkg.sv @@
// Shared constants, codes and control structs of the chained hash map.
`timescale 1ns / 1ps

package chm_pkg;

	// Default table geometry.
	localparam int CHM_BUCKET_COUNT = 251;
	localparam int CHM_NODE_COUNT = 256;

	// djb2 starting value.
	localparam logic [31:0] HASH_SEED = 32'd5381;

	// Request commands.
	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_INSERT_RO = 3'd1;
	localparam logic [2:0] CMD_LOOKUP = 3'd2;
	localparam logic [2:0] CMD_LOOKUP_RO = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	// Result status codes.
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EXISTS = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_NOT_PERMITTED = 3'd3;
	localparam logic [2:0] ST_FULL = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;
		logic hash_load;
		logic hash_step;
		logic mod_init;
		logic mod_step;
		logic head_take;
		logic node_take;
		logic exec;
		logic scan_rd;
		logic scan_take;
		logic out_load;
	} chm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_end;
		logic walk_end;
		logic key_match;
		logic ins_ok;
		logic scan_end;
		logic scan_free;
	} chm_stat_t;

endpackage

@@ sv/chained_hash_key_value_map_unit.sv @@
// Top level of the chained hash key-value map.
//
// Channel | Direction | Handshake           | Word
// input   | in        | in_valid / in_ready | cmd, lookup_key, entry_value
// output  | out       | out_valid/out_ready | status, found_value
//
// A request runs four hash steps, three reduction steps by reciprocal
// multiplication, and a walk over the chain with a node memory read per node
// visited. An insert then scans the allocation map for the next free node.
// After reset a clearing pass over the bucket heads and the allocation map runs
// before the first word is taken.
// A new word is taken while an earlier result still waits in the output register.
`timescale 1ns / 1ps

module chained_hash_key_value_map_unit import chm_pkg::*; #(
	parameter int BUCKET_COUNT = CHM_BUCKET_COUNT,
	parameter int NODE_COUNT = CHM_NODE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] lookup_key,
	input  logic [31:0] entry_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] found_value
);

	chm_cmd_t  ctl;
	chm_stat_t stat;

	// Sequencer.
	chm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.stat(stat), .ctl(ctl)
	);

	// Hash, walk and memories.
	chm_dp #(.BUCKET_COUNT(BUCKET_COUNT), .NODE_COUNT(NODE_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat),
		.cmd(cmd), .lookup_key(lookup_key), .entry_value(entry_value),
		.status(status), .found_value(found_value)
	);

endmodule

@@ sv/chm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/chm_dp.sv @@
// Datapath of the chained hash map: hash, bucket reduction, chain walk and table memories.
`timescale 1ns / 1ps

module chm_dp import chm_pkg::*; #(
	parameter int BUCKET_COUNT = CHM_BUCKET_COUNT,
	parameter int NODE_COUNT = CHM_NODE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  chm_cmd_t    ctl,
	output chm_stat_t   stat,
	input  logic [2:0]  cmd,
	input  logic [31:0] lookup_key,
	input  logic [31:0] entry_value,
	output logic [2:0]  status,
	output logic [31:0] found_value
);

	localparam int NW = $clog2(NODE_COUNT + 1);
	localparam int NA = $clog2(NODE_COUNT);
	localparam int BW = $clog2(BUCKET_COUNT);
	localparam int MAXC = (BUCKET_COUNT > NODE_COUNT) ? BUCKET_COUNT : NODE_COUNT;
	localparam int CW = $clog2(MAXC + 1);
	localparam int WW = 65 + NW;
	localparam logic [NW-1:0] NIL = NW'(NODE_COUNT);
	localparam int KS = 32 + BW;
	localparam logic [32:0] RMUL =
		33'(((64'd1 << KS) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));

	logic [2:0]    cmd_q;
	logic [31:0]   key_q, val_q, hash_q, hkey_q, msh_q;
	logic [BW-1:0] rem_q, rem_d;
	logic [48:0]   plo_q, phi_q;
	logic [31:0]   quo_q, quo_d, rem_full;
	logic [64:0]   prod_sum;
	logic [NW-1:0] head_q, cur_q, prev_q, steps_q, lowfree_q, scan_q;
	logic [WW-1:0] prevw_q, hitw_q;
	logic          found_q;
	logic [CW-1:0] clr_q;
	logic [2:0]    res_status_q;
	logic [31:0]   res_value_q;

	logic          bk_we, iu_we, nd_we, iu_wdata, iu_rdata;
	logic [BW-1:0] bk_waddr;
	logic [NW-1:0] bk_wdata, bk_rdata;
	logic [NA-1:0] iu_waddr, nd_waddr;
	logic [WW-1:0] nd_wdata, nd_rdata;
	logic [2:0]    st_d;
	logic [31:0]   val_d;

	// Bucket index by reciprocal multiplication: partial products, quotient, remainder.
	assign prod_sum = {phi_q, 16'd0} + {16'd0, plo_q};
	assign quo_d = 32'(prod_sum >> KS);
	assign rem_full = msh_q - quo_q * 32'(BUCKET_COUNT);
	assign rem_d = rem_full[BW-1:0];

	assign stat.clr_end = (clr_q == CW'(MAXC - 1));
	assign stat.walk_end = (cur_q == NIL) || (steps_q == NW'(NODE_COUNT));
	assign stat.key_match = (nd_rdata[WW-1:WW-32] == key_q);
	assign stat.ins_ok = ((cmd_q == CMD_INSERT) || (cmd_q == CMD_INSERT_RO)) &&
		!found_q && (lowfree_q != NIL);
	assign stat.scan_end = (scan_q == NIL);
	assign stat.scan_free = !iu_rdata;

	// Result and memory writes of the clearing pass and the execute step.
	always_comb begin
		st_d = ST_NOT_PERMITTED;
		val_d = '0;
		bk_we = 1'b0;
		bk_waddr = rem_q;
		bk_wdata = lowfree_q;
		nd_we = 1'b0;
		nd_waddr = lowfree_q[NA-1:0];
		nd_wdata = {key_q, val_q, (cmd_q == CMD_INSERT_RO), head_q};
		iu_we = 1'b0;
		iu_waddr = lowfree_q[NA-1:0];
		iu_wdata = 1'b1;
		if (ctl.clr) begin
			bk_we = (clr_q < CW'(BUCKET_COUNT));
			bk_waddr = clr_q[BW-1:0];
			bk_wdata = NIL;
			iu_we = (clr_q < CW'(NODE_COUNT));
			iu_waddr = clr_q[NA-1:0];
			iu_wdata = 1'b0;
		end else if (ctl.exec) begin
			case (cmd_q)
				CMD_INSERT, CMD_INSERT_RO: begin
					if (found_q) begin
						st_d = ST_EXISTS;
					end else if (lowfree_q == NIL) begin
						st_d = ST_FULL;
					end else begin
						st_d = ST_OK;
						bk_we = 1'b1;
						nd_we = 1'b1;
						iu_we = 1'b1;
					end
				end
				CMD_LOOKUP, CMD_LOOKUP_RO: begin
					if (!found_q) begin
						st_d = ST_NOT_FOUND;
					end else if (cmd_q == CMD_LOOKUP && hitw_q[NW]) begin
						st_d = ST_NOT_PERMITTED;
					end else begin
						st_d = ST_OK;
						val_d = hitw_q[NW+32:NW+1];
					end
				end
				CMD_REMOVE: begin
					if (!found_q) begin
						st_d = ST_NOT_FOUND;
					end else begin
						st_d = ST_OK;
						iu_we = 1'b1;
						iu_waddr = cur_q[NA-1:0];
						iu_wdata = 1'b0;
						if (prev_q == NIL) begin
							bk_we = 1'b1;
							bk_wdata = hitw_q[NW-1:0];
						end else begin
							nd_we = 1'b1;
							nd_waddr = prev_q[NA-1:0];
							nd_wdata = {prevw_q[WW-1:NW], hitw_q[NW-1:0]};
						end
					end
				end
				default: begin
					st_d = ST_NOT_PERMITTED;
				end
			endcase
		end
	end

	// Control registers: clear counter, lowest free node and scan pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			lowfree_q <= '0;
			scan_q <= '0;
		end else begin
			if (ctl.clr) begin
				clr_q <= clr_q + CW'(1);
			end
			if (ctl.exec && stat.ins_ok) begin
				scan_q <= lowfree_q + NW'(1);
			end
			if (ctl.exec && cmd_q == CMD_REMOVE && found_q && cur_q < lowfree_q) begin
				lowfree_q <= cur_q;
			end
			if (ctl.scan_rd && stat.scan_end) begin
				lowfree_q <= NIL;
			end
			if (ctl.scan_take) begin
				if (!iu_rdata) begin
					lowfree_q <= scan_q;
				end else begin
					scan_q <= scan_q + NW'(1);
				end
			end
		end
	end

	// Payload registers of the hash, the reduction, the chain walk, the result and the output word.
	always_ff @(posedge clk) begin
		if (ctl.hash_load) begin
			cmd_q <= cmd;
			key_q <= lookup_key;
			val_q <= entry_value;
			hkey_q <= lookup_key;
			hash_q <= HASH_SEED;
		end
		if (ctl.hash_step) begin
			hash_q <= (hash_q << 5) + hash_q + {24'd0, hkey_q[7:0]};
			hkey_q <= hkey_q >> 8;
		end
		if (ctl.mod_init) begin
			msh_q <= hash_q;
		end
		if (ctl.mod_step) begin
			plo_q <= 49'(msh_q[15:0]) * 49'(RMUL);
			phi_q <= 49'(msh_q[31:16]) * 49'(RMUL);
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
		if (ctl.head_take) begin
			head_q <= bk_rdata;
			cur_q <= bk_rdata;
			prev_q <= NIL;
			steps_q <= '0;
			found_q <= 1'b0;
		end
		if (ctl.node_take) begin
			if (stat.key_match) begin
				found_q <= 1'b1;
				hitw_q <= nd_rdata;
			end else begin
				prev_q <= cur_q;
				prevw_q <= nd_rdata;
				cur_q <= nd_rdata[NW-1:0];
				steps_q <= steps_q + NW'(1);
			end
		end
		if (ctl.exec) begin
			res_status_q <= st_d;
			res_value_q <= val_d;
		end
		if (ctl.out_load) begin
			status <= res_status_q;
			found_value <= res_value_q;
		end
	end

	// Bucket heads.
	chm_ram #(.WIDTH(NW), .DEPTH(BUCKET_COUNT)) u_bucket (
		.clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
		.raddr(rem_q), .rdata(bk_rdata)
	);

	// Node words: key, data, read-only flag, link.
	chm_ram #(.WIDTH(WW), .DEPTH(NODE_COUNT)) u_node (
		.clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
		.raddr(cur_q[NA-1:0]), .rdata(nd_rdata)
	);

	// Node allocation map.
	chm_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_in_use (
		.clk(clk), .we(iu_we), .waddr(iu_waddr), .wdata(iu_wdata),
		.raddr(scan_q[NA-1:0]), .rdata(iu_rdata)
	);

endmodule

@@ sv/chm_ctrl.sv @@
// Controller state machine of the chained hash map.
`timescale 1ns / 1ps

module chm_ctrl import chm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  chm_stat_t stat,
	output chm_cmd_t  ctl
);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_MINIT = 4'd3;
	localparam logic [3:0] S_MOD = 4'd4;
	localparam logic [3:0] S_HEAD = 4'd5;
	localparam logic [3:0] S_HWAIT = 4'd6;
	localparam logic [3:0] S_WALK = 4'd7;
	localparam logic [3:0] S_NWAIT = 4'd8;
	localparam logic [3:0] S_EXEC = 4'd9;
	localparam logic [3:0] S_SCAN = 4'd10;
	localparam logic [3:0] S_SWAIT = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0] state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		ctl = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (stat.clr_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					ctl.hash_load = 1'b1;
					cnt_d = '0;
					state_d = S_HASH;
				end
			end
			S_HASH: begin
				ctl.hash_step = 1'b1;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd3) state_d = S_MINIT;
			end
			S_MINIT: begin
				ctl.mod_init = 1'b1;
				cnt_d = '0;
				state_d = S_MOD;
			end
			S_MOD: begin
				ctl.mod_step = 1'b1;
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == 3'd2) state_d = S_HEAD;
			end
			S_HEAD: begin
				state_d = S_HWAIT;
			end
			S_HWAIT: begin
				ctl.head_take = 1'b1;
				state_d = S_WALK;
			end
			S_WALK: begin
				if (stat.walk_end) begin
					state_d = S_EXEC;
				end else begin
					state_d = S_NWAIT;
				end
			end
			S_NWAIT: begin
				ctl.node_take = 1'b1;
				state_d = stat.key_match ? S_EXEC : S_WALK;
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				state_d = stat.ins_ok ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				ctl.scan_rd = 1'b1;
				state_d = stat.scan_end ? S_DONE : S_SWAIT;
			end
			S_SWAIT: begin
				ctl.scan_take = 1'b1;
				state_d = stat.scan_free ? S_DONE : S_SCAN;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, step counter and output word flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
